// ===== design/brs_pkg.sv =====
// Shared constants, types and helper functions of the bar raster scan sequencer.
`default_nettype none
package brs_pkg;

	localparam int ANGLE_WIDTH = 24;
	// work width for offset and command sums, one bit above the wider of ANGLE_WIDTH and 26 bits
	localparam int CW = ((ANGLE_WIDTH > 26) ? ANGLE_WIDTH : 26) + 1;
	localparam int REF_W = 24;
	localparam int SPAN_W = 23;
	localparam int BAR_W = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_BAR_COUNT     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_TO_RIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VERTICAL_MODE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BAR_SPACING   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_REF_AZ        = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_REF_EL        = 3'd6;

	typedef struct packed {
		logic [BAR_W-1:0]        bar_count;
		logic                    left_to_right;
		logic                    vertical_mode;
		logic [SPAN_W-1:0]       half_width;
		logic [SPAN_W-1:0]       bar_spacing;
		logic signed [REF_W-1:0] ref_az;
		logic signed [REF_W-1:0] ref_el;
	} cfg_t;

	typedef struct packed {
		logic             fast_slew;
		logic             bar_started;
		logic             bar_ended;
		logic [BAR_W-1:0] bar_index;
		logic             reverse_pass;
	} flags_t;

	// zero counts as one bar, anything above four as four
	function automatic logic [BAR_W-1:0] eff_count(input logic [BAR_W-1:0] bc);
		logic [BAR_W-1:0] r;
		if (bc == '0) begin
			r = BAR_W'(1);
		end else if (bc > BAR_W'(4)) begin
			r = BAR_W'(4);
		end else begin
			r = bc;
		end
		return r;
	endfunction

	function automatic logic signed [ANGLE_WIDTH-1:0] sat_angle(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] hi;
		logic signed [CW-1:0] lo;
		logic signed [ANGLE_WIDTH-1:0] r;
		hi = {{(CW-ANGLE_WIDTH+1){1'b0}}, {(ANGLE_WIDTH-1){1'b1}}};
		lo = {{(CW-ANGLE_WIDTH+1){1'b1}}, {(ANGLE_WIDTH-1){1'b0}}};
		if (v > hi) begin
			r = hi[ANGLE_WIDTH-1:0];
		end else if (v < lo) begin
			r = lo[ANGLE_WIDTH-1:0];
		end else begin
			r = v[ANGLE_WIDTH-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/brs_if.sv =====
// Channel interfaces: control tick input, scan command output, register write.
`default_nettype none
interface brs_tick_if;
	import brs_pkg::*;
	logic valid;
	logic ready;
	logic settled;
	logic restart;
	modport source (output valid, input ready, output settled, output restart);
	modport sink (input valid, output ready, input settled, input restart);
endinterface

interface brs_res_if;
	import brs_pkg::*;
	logic                          valid;
	logic                          ready;
	logic signed [ANGLE_WIDTH-1:0] cmd_az;
	logic signed [ANGLE_WIDTH-1:0] cmd_el;
	logic                          fast_slew;
	logic                          bar_started;
	logic                          bar_ended;
	logic [BAR_W-1:0]              bar_index;
	logic                          reverse_pass;
	modport source (output valid, input ready, output cmd_az, output cmd_el,
		output fast_slew, output bar_started, output bar_ended, output bar_index,
		output reverse_pass);
	modport sink (input valid, output ready, input cmd_az, input cmd_el,
		input fast_slew, input bar_started, input bar_ended, input bar_index,
		input reverse_pass);
endinterface

interface brs_cfg_if;
	import brs_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, input ready, output index, output data);
	modport sink (input valid, output ready, input index, input data);
endinterface
`default_nettype wire

// ===== design/brs_cfg.sv =====
// Configuration register file of the scan sequencer.
`default_nettype none
module brs_cfg (
	input  logic          clk,
	input  logic          arst_n,
	brs_cfg_if.sink       cfg,
	output brs_pkg::cfg_t regs,
	output logic          clr_rev
);
	import brs_pkg::*;

	cfg_t             regs_q;
	logic             wr;
	logic [BAR_W-1:0] new_count;

	assign cfg.ready = 1'b1;
	assign wr = cfg.valid && cfg.ready;
	assign regs = regs_q;

	// an even bar count drops any reverse pass in progress
	assign new_count = eff_count(cfg.data[BAR_W-1:0]);
	assign clr_rev = wr && (cfg.index == REG_BAR_COUNT) && !new_count[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.bar_count     <= BAR_W'(1);
			regs_q.left_to_right <= 1'b1;
			regs_q.vertical_mode <= 1'b0;
			regs_q.half_width    <= '0;
			regs_q.bar_spacing   <= '0;
			regs_q.ref_az        <= '0;
			regs_q.ref_el        <= '0;
		end else if (wr) begin
			case (cfg.index)
				REG_BAR_COUNT:     regs_q.bar_count <= cfg.data[BAR_W-1:0];
				REG_LEFT_TO_RIGHT: regs_q.left_to_right <= cfg.data[0];
				REG_VERTICAL_MODE: regs_q.vertical_mode <= cfg.data[0];
				REG_HALF_WIDTH:    regs_q.half_width <= cfg.data[SPAN_W-1:0];
				REG_BAR_SPACING:   regs_q.bar_spacing <= cfg.data[SPAN_W-1:0];
				REG_REF_AZ:        regs_q.ref_az <= $signed(cfg.data[REF_W-1:0]);
				REG_REF_EL:        regs_q.ref_el <= $signed(cfg.data[REF_W-1:0]);
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== design/brs_ctrl.sv =====
// Scan phase sequencer and bar endpoint placement, first pipeline stage.
`default_nettype none
module brs_ctrl (
	input  logic                                   clk,
	input  logic                                   arst_n,
	brs_tick_if.sink                               tick,
	input  brs_pkg::cfg_t                          regs,
	input  logic                                   clr_rev,
	input  logic                                   s2_ready,
	output logic                                   v_s1,
	output brs_pkg::flags_t                        flags_s1,
	output logic signed [brs_pkg::ANGLE_WIDTH-1:0] off_x,
	output logic signed [brs_pkg::ANGLE_WIDTH-1:0] off_y
);
	import brs_pkg::*;

	localparam logic [1:0] PH_RESET = 2'd0;
	localparam logic [1:0] PH_START = 2'd1;
	localparam logic [1:0] PH_END   = 2'd2;

	logic [1:0]                    phase_q, ph, phase_d;
	logic [BAR_W-1:0]              bar_q, bar_d, n, pbar, bar_lo;
	logic [BAR_W:0]                bar_inc;
	logic                          rev_q, rev_d, slew_q, slew_d;
	logic                          started, ended, at_end, do_place, accept, x_neg;
	logic                          v_s1_q;
	logic signed [4:0]             yh;
	logic [4:0]                    yabs;
	logic [SPAN_W+1:0]             prod, prod_r;
	logic signed [CW-1:0]          hw_w, mag_w, x_w, y_w;
	logic signed [ANGLE_WIDTH-1:0] x1, y1, offx_q, offy_q;
	flags_t                        flags_q;

	assign tick.ready = !v_s1_q || s2_ready;
	assign accept = tick.valid && tick.ready;
	assign n = eff_count(regs.bar_count);
	assign v_s1 = v_s1_q;
	assign flags_s1 = flags_q;
	assign off_x = offx_q;
	assign off_y = offy_q;

	assign bar_lo = (bar_q == '0) ? BAR_W'(1) : bar_q;
	assign bar_inc = {1'b0, bar_q} + (BAR_W+1)'(1);

	always_comb begin
		ph = tick.restart ? PH_RESET : phase_q;
		phase_d = phase_q;
		bar_d = bar_q;
		rev_d = rev_q;
		slew_d = slew_q;
		started = 1'b0;
		ended = 1'b0;
		at_end = 1'b0;
		do_place = 1'b0;
		case (ph)
			PH_START: begin
				if (tick.settled) begin
					started = 1'b1;
					at_end = 1'b1;
					do_place = 1'b1;
					phase_d = PH_END;
					slew_d = 1'b0;
				end
			end
			PH_END: begin
				if (tick.settled) begin
					ended = 1'b1;
					do_place = 1'b1;
					phase_d = PH_START;
					slew_d = 1'b1;
					// odd counts bounce between the first and last bar, even counts wrap
					if (n[0]) begin
						if (n == BAR_W'(1)) begin
							rev_d = !rev_q;
						end else if (bar_q >= n) begin
							rev_d = 1'b1;
							bar_d = n - BAR_W'(1);
						end else if (rev_q && (bar_q > BAR_W'(1))) begin
							bar_d = bar_q - BAR_W'(1);
						end else begin
							bar_d = bar_lo + BAR_W'(1);
							rev_d = 1'b0;
						end
					end else begin
						rev_d = 1'b0;
						bar_d = (bar_inc > {1'b0, n}) ? BAR_W'(1) : bar_inc[BAR_W-1:0];
					end
				end
			end
			default: begin
				bar_d = BAR_W'(1);
				do_place = 1'b1;
				phase_d = PH_START;
				slew_d = 1'b1;
			end
		endcase
	end

	// endpoint of the bar chosen for this tick
	always_comb begin
		if (bar_d > n) begin
			pbar = n;
		end else if (bar_d == '0) begin
			pbar = BAR_W'(1);
		end else begin
			pbar = bar_d;
		end
		x_neg = pbar[0] ^ at_end ^ !regs.left_to_right ^ ((n == BAR_W'(1)) && rev_d);
		hw_w = CW'(regs.half_width);
		x_w = x_neg ? -hw_w : hw_w;
		yh = $signed({2'b00, n} + 5'd1 - {1'b0, pbar, 1'b0});
		yabs = yh[4] ? 5'(-yh) : 5'(yh);
		// times zero to three by shift and add, then round half away from zero
		prod = (yabs[0] ? {2'b00, regs.bar_spacing} : '0)
			+ (yabs[1] ? {1'b0, regs.bar_spacing, 1'b0} : '0);
		prod_r = prod + (SPAN_W+2)'(1);
		mag_w = CW'(prod_r[SPAN_W+1:1]);
		y_w = yh[4] ? -mag_w : mag_w;
		x1 = sat_angle(x_w);
		y1 = sat_angle(y_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RESET;
			bar_q <= BAR_W'(1);
			rev_q <= 1'b0;
			slew_q <= 1'b0;
			offx_q <= '0;
			offy_q <= '0;
			flags_q <= '0;
			v_s1_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q <= phase_d;
				bar_q <= bar_d;
				rev_q <= rev_d;
				slew_q <= slew_d;
				if (do_place) begin
					offx_q <= regs.vertical_mode ? y1 : x1;
					offy_q <= regs.vertical_mode ? x1 : y1;
				end
				flags_q.fast_slew <= slew_d;
				flags_q.bar_started <= started;
				flags_q.bar_ended <= ended;
				flags_q.bar_index <= ended ? bar_q : bar_d;
				flags_q.reverse_pass <= rev_d;
			end else if (clr_rev) begin
				rev_q <= 1'b0;
			end
			if (accept) begin
				v_s1_q <= 1'b1;
			end else if (s2_ready) begin
				v_s1_q <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	a_phase_after_tick: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (phase_q == PH_START || phase_q == PH_END))
		else $error("phase left start/end after a tick");
	a_hold_stage1: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1_q && !s2_ready |=> $stable(offx_q) && $stable(offy_q) && $stable(flags_q))
		else $error("stage one changed while stalled");
	a_start_event: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !tick.restart && tick.settled && phase_q == PH_START
		|=> flags_q.bar_started && !flags_q.fast_slew)
		else $error("settled start phase did not begin a sweep");
`endif

endmodule
`default_nettype wire

// ===== design/brs_out.sv =====
// Command summation with saturation and the output register.
`default_nettype none
module brs_out (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  brs_pkg::cfg_t                          regs,
	input  logic                                   v_s1,
	input  brs_pkg::flags_t                        flags_s1,
	input  logic signed [brs_pkg::ANGLE_WIDTH-1:0] off_x,
	input  logic signed [brs_pkg::ANGLE_WIDTH-1:0] off_y,
	output logic                                   s2_ready,
	brs_res_if.source                              res
);
	import brs_pkg::*;

	logic                          valid_q;
	flags_t                        flags_q;
	logic signed [ANGLE_WIDTH-1:0] az_q, el_q;
	logic signed [CW-1:0]          az_sum, el_sum;

	assign s2_ready = !valid_q || res.ready;
	assign az_sum = CW'(regs.ref_az) + CW'(off_x);
	assign el_sum = CW'(regs.ref_el) + CW'(off_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s2_ready) begin
			valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && v_s1) begin
			az_q <= sat_angle(az_sum);
			el_q <= sat_angle(el_sum);
			flags_q <= flags_s1;
		end
	end

	assign res.valid = valid_q;
	assign res.cmd_az = az_q;
	assign res.cmd_el = el_q;
	assign res.fast_slew = flags_q.fast_slew;
	assign res.bar_started = flags_q.bar_started;
	assign res.bar_ended = flags_q.bar_ended;
	assign res.bar_index = flags_q.bar_index;
	assign res.reverse_pass = flags_q.reverse_pass;

`ifndef SYNTH
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && s2_ready |=> res.valid && res.bar_index == $past(flags_s1.bar_index))
		else $error("stage one item not moved to output");
	// a sweep start goes slow, a sweep end goes fast
	a_event_excl: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && s2_ready |=> !(res.bar_started && res.bar_ended)
		&& (!res.bar_started || !res.fast_slew) && (!res.bar_ended || res.fast_slew))
		else $error("bar events inconsistent with slew");
`endif

endmodule
`default_nettype wire

// ===== design/bar_raster_scan_sequencer_top.sv =====
// Top level of the bar raster scan sequencer.
// Usage:
//   tick : one control tick per transfer (settled, restart). Each accepted tick
//          yields exactly one result transfer on res, in order.
//   res  : commanded azimuth/elevation (reference plus scan offset, saturated),
//          fast_slew, bar_started/bar_ended pulses, bar_index, reverse_pass.
//   cfg  : register writes (index, data), always ready; write only while idle.
// From tick transfer to res valid, the sequencer and endpoint placement register
// into stage one, then the command adders and saturation register into the
// output stage. Throughput is one tick per cycle while res is not stalled;
// the phase/bar state loop closes within stage one.
// When res is stalled the output register holds, stage one fills, and then
// tick.ready drops until res takes a transfer; nothing is lost or repeated.
// Reset (arst_n low) clears the pipeline, sets the scan to its reset phase
// on bar 1 and loads the default registers: one bar, left to right,
// horizontal, zero width, spacing and reference.
`default_nettype none
module bar_raster_scan_sequencer_top (
	input logic        clk,
	input logic        arst_n,
	brs_tick_if.sink   tick,
	brs_res_if.source  res,
	brs_cfg_if.sink    cfg
);
	import brs_pkg::*;

	cfg_t                          regs;
	logic                          clr_rev;
	logic                          s2_ready;
	logic                          v_s1;
	flags_t                        flags_s1;
	logic signed [ANGLE_WIDTH-1:0] off_x, off_y;

	brs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.regs    (regs),
		.clr_rev (clr_rev)
	);

	brs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (tick),
		.regs     (regs),
		.clr_rev  (clr_rev),
		.s2_ready (s2_ready),
		.v_s1     (v_s1),
		.flags_s1 (flags_s1),
		.off_x    (off_x),
		.off_y    (off_y)
	);

	brs_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.regs     (regs),
		.v_s1     (v_s1),
		.flags_s1 (flags_s1),
		.off_x    (off_x),
		.off_y    (off_y),
		.s2_ready (s2_ready),
		.res      (res)
	);

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench of the bar raster scan sequencer: directed and random control ticks.
`timescale 1ns / 100ps
module tb;
	import brs_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int STUCK_LIMIT = 2000;

	typedef enum logic [1:0] {
		PH_RESET = 2'd0,
		PH_START = 2'd1,
		PH_END   = 2'd2
	} scan_phase_e;

	typedef struct {
		logic signed [ANGLE_WIDTH-1:0] az;
		logic signed [ANGLE_WIDTH-1:0] el;
		flags_t                        fl;
	} scan_cmd_t;

	logic clk;
	logic arst_n;

	brs_tick_if tick_ch();
	brs_res_if  res_ch();
	brs_cfg_if  cfg_ch();

	bar_raster_scan_sequencer_top dut (
		.clk   (clk),
		.arst_n(arst_n),
		.tick  (tick_ch),
		.res   (res_ch),
		.cfg   (cfg_ch)
	);

	// predicted scan state
	scan_phase_e phase_q = PH_RESET;
	int unsigned bar_q = 1;
	bit          rev_q = 1'b0;
	bit          slew_q = 1'b0;
	longint      off_x = 0;
	longint      off_y = 0;

	// shadow of the register file
	logic [BAR_W-1:0] count_r = 3'd1;
	bit               ltr_r = 1'b1;
	bit               vert_r = 1'b0;
	longint           half_w_r = 0;
	longint           spacing_r = 0;
	longint           ref_az_r = 0;
	longint           ref_el_r = 0;

	scan_cmd_t   cmd_expected[$];
	int unsigned ticks_sent = 0;
	int unsigned cmds_checked = 0;
	int unsigned reg_writes = 0;
	int unsigned errors = 0;
	int unsigned stuck_cycles = 0;
	bit          steady_tail = 1'b0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint clip(longint v);
		longint hi;
		hi = (longint'(1) <<< (ANGLE_WIDTH - 1)) - 1;
		if (v > hi) begin
			return hi;
		end
		if (v < -hi - 1) begin
			return -hi - 1;
		end
		return v;
	endfunction

	function automatic int unsigned bars_in_use();
		if (count_r == 0) begin
			return 1;
		end
		if (count_r > 4) begin
			return 4;
		end
		return count_r;
	endfunction

	function automatic void place_endpoint(int unsigned bar, bit at_end);
		int unsigned n;
		int          xs;
		int          yh;
		longint      x1;
		longint      y1;
		longint      mag;
		n = bars_in_use();
		if (bar > n) begin
			bar = n;
		end
		if (bar < 1) begin
			bar = 1;
		end
		xs = (bar % 2 == 1) ? -1 : 1;
		if (at_end) begin
			xs = -xs;
		end
		if (!ltr_r) begin
			xs = -xs;
		end
		if (n == 1 && rev_q) begin
			xs = -xs;
		end
		yh = int'(n) + 1 - 2 * int'(bar);
		x1 = clip(xs * half_w_r);
		// round half away from zero on the half-spacing grid
		mag = (longint'(yh < 0 ? -yh : yh) * spacing_r + 1) >> 1;
		y1 = clip(yh < 0 ? -mag : mag);
		if (vert_r) begin
			off_x = y1;
			off_y = x1;
		end else begin
			off_x = x1;
			off_y = y1;
		end
	endfunction

	function automatic void next_bar();
		int unsigned n;
		int unsigned b;
		n = bars_in_use();
		b = bar_q;
		if (n % 2 == 1) begin
			if (n == 1) begin
				rev_q = !rev_q;
			end else if (b >= n) begin
				rev_q = 1'b1;
				bar_q = n - 1;
			end else if (rev_q && b > 1) begin
				bar_q = b - 1;
			end else begin
				if (b < 1) begin
					b = 1;
				end
				bar_q = b + 1;
				rev_q = 1'b0;
			end
		end else begin
			rev_q = 1'b0;
			b = b + 1;
			if (b > n) begin
				b = 1;
			end
			bar_q = b;
		end
	endfunction

	function automatic scan_cmd_t scan_step(bit settled, bit restart);
		scan_cmd_t   r;
		bit          began;
		bit          done;
		int unsigned idx;
		began = 1'b0;
		done = 1'b0;
		if (restart) begin
			phase_q = PH_RESET;
		end
		idx = bar_q;
		case (phase_q)
			PH_START: begin
				if (settled) begin
					began = 1'b1;
					place_endpoint(bar_q, 1'b1);
					phase_q = PH_END;
					slew_q = 1'b0;
				end
			end
			PH_END: begin
				if (settled) begin
					done = 1'b1;
					next_bar();
					place_endpoint(bar_q, 1'b0);
					phase_q = PH_START;
					slew_q = 1'b1;
				end
			end
			default: begin
				bar_q = 1;
				place_endpoint(1, 1'b0);
				phase_q = PH_START;
				slew_q = 1'b1;
			end
		endcase
		// an end event reports the bar that just finished
		if (!done) begin
			idx = bar_q;
		end
		r.az = ANGLE_WIDTH'(clip(ref_az_r + off_x));
		r.el = ANGLE_WIDTH'(clip(ref_el_r + off_y));
		r.fl.fast_slew = slew_q;
		r.fl.bar_started = began;
		r.fl.bar_ended = done;
		r.fl.bar_index = BAR_W'(idx);
		r.fl.reverse_pass = rev_q;
		return r;
	endfunction

	task automatic send_tick(input bit settled, input bit restart);
		tick_ch.valid <= 1'b1;
		tick_ch.settled <= settled;
		tick_ch.restart <= restart;
		@(posedge clk);
		while (!tick_ch.ready) begin
			@(posedge clk);
		end
		cmd_expected.push_back(scan_step(settled, restart));
		ticks_sent++;
		if (!steady_tail && $urandom_range(0, 7) == 0) begin
			tick_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready) begin
			@(posedge clk);
		end
		case (idx)
			REG_BAR_COUNT: begin
				count_r = value[BAR_W-1:0];
				if (bars_in_use() % 2 == 0) begin
					rev_q = 1'b0;
				end
			end
			REG_LEFT_TO_RIGHT: ltr_r = value[0];
			REG_VERTICAL_MODE: vert_r = value[0];
			REG_HALF_WIDTH:    half_w_r = longint'(value[SPAN_W-1:0]);
			REG_BAR_SPACING:   spacing_r = longint'(value[SPAN_W-1:0]);
			REG_REF_AZ:        ref_az_r = longint'($signed(value[REF_W-1:0]));
			REG_REF_EL:        ref_el_r = longint'($signed(value[REF_W-1:0]));
			default: ;
		endcase
		reg_writes++;
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// drop tick valid and let the pipeline drain
	task automatic wait_idle();
		tick_ch.valid <= 1'b0;
		while (cmd_expected.size() != 0) begin
			@(posedge clk);
		end
		repeat (3) @(posedge clk);
	endtask

	function automatic void check_field(string what, longint want, longint got);
		if (want != got) begin
			errors++;
			$display("%0t mismatch on %s: expected %0d, actual %0d", $time, what, want, got);
		end
	endfunction

	always @(posedge clk) begin : check_results
		scan_cmd_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			cmds_checked++;
			if (cmd_expected.size() == 0) begin
				errors++;
				$display("%0t scan command with nothing expected: expected none, actual az %0d el %0d",
					$time, res_ch.cmd_az, res_ch.cmd_el);
			end else begin
				want = cmd_expected.pop_front();
				check_field("cmd_az", want.az, res_ch.cmd_az);
				check_field("cmd_el", want.el, res_ch.cmd_el);
				check_field("fast_slew", want.fl.fast_slew, res_ch.fast_slew);
				check_field("bar_started", want.fl.bar_started, res_ch.bar_started);
				check_field("bar_ended", want.fl.bar_ended, res_ch.bar_ended);
				check_field("bar_index", want.fl.bar_index, res_ch.bar_index);
				check_field("reverse_pass", want.fl.reverse_pass, res_ch.reverse_pass);
			end
		end
	end

	always @(posedge clk) begin
		if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("%0t no transfer for %0d cycles", $time, STUCK_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// receiver stalls in random bursts
	initial begin
		res_ch.ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (!steady_tail && $urandom_range(0, 9) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				res_ch.ready <= 1'b1;
			end
		end
	end

	task automatic test_reset_phase();
		// reset phase runs whether or not the servo has settled
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b1);
	endtask

	task automatic test_extreme_settings();
		wait_idle();
		write_reg(REG_BAR_COUNT, 24'd3);
		write_reg(REG_LEFT_TO_RIGHT, 24'd0);
		write_reg(REG_VERTICAL_MODE, 24'd1);
		write_reg(REG_HALF_WIDTH, 24'hFFFFFF);
		write_reg(REG_BAR_SPACING, 24'hFFFFFF);
		write_reg(REG_REF_AZ, 24'h7FFFFF);
		write_reg(REG_REF_EL, 24'h800000);
		repeat (6) send_tick(1'b1, 1'b0);
		wait_idle();
		write_reg(REG_REF_AZ, 24'h800000);
		write_reg(REG_REF_EL, 24'h7FFFFF);
		write_reg(REG_VERTICAL_MODE, 24'd0);
		write_reg(REG_LEFT_TO_RIGHT, 24'd1);
		write_reg(REG_UNUSED, 24'hA5A5A5);
		repeat (6) send_tick(1'b1, 1'b0);
	endtask

	task automatic test_odd_reverse();
		wait_idle();
		write_reg(REG_BAR_COUNT, 24'd3);
		send_tick(1'b1, 1'b1);
		// run through bar three so the raster turns around
		repeat (6) send_tick(1'b1, 1'b0);
		wait_idle();
		// even count clears the reverse pass
		write_reg(REG_BAR_COUNT, 24'd4);
		send_tick(1'b1, 1'b0);
		send_tick(1'b1, 1'b0);
		wait_idle();
		// current bar now lies beyond the count
		write_reg(REG_BAR_COUNT, 24'd2);
		send_tick(1'b1, 1'b0);
		send_tick(1'b1, 1'b0);
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_reg_value();
		case ($urandom_range(0, 5))
			0: return CFG_DATA_W'($urandom_range(0, 4095));
			1: return 24'h7FFFFF;
			2: return 24'h800000;
			3: return 24'hFFFFFF;
			4: return '0;
			default: return CFG_DATA_W'($urandom);
		endcase
	endfunction

	task automatic test_random_scans();
		int unsigned left;
		int unsigned len;
		left = 550;
		while (left != 0) begin
			wait_idle();
			steady_tail = (left <= 120);
			repeat ($urandom_range(1, 7)) begin
				write_reg(CFG_IDX_W'($urandom_range(0, 7)), pick_reg_value());
			end
			len = $urandom_range(15, 60);
			if (len > left) begin
				len = left;
			end
			repeat (len) begin
				send_tick($urandom_range(0, 9) < 7, $urandom_range(0, 39) == 0);
			end
			left -= len;
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		tick_ch.valid <= 1'b0;
		tick_ch.settled <= 1'b0;
		tick_ch.restart <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_phase();
		test_extreme_settings();
		test_odd_reverse();
		test_random_scans();
		wait_idle();
		repeat (8) @(posedge clk);
		$display("Ran %0d control ticks, checked %0d scan commands, made %0d register writes",
			ticks_sent, cmds_checked, reg_writes);
		$display("Rasters of every bar count code, both directions and axis modes, saturated angles");
		if (errors == 0 && cmd_expected.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
